@@ hdl/otu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the timer/UART register block.
// No dependencies.
package otu_pkg;

  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;
  localparam logic [1:0] ACT_NOP     = 2'd3;

  localparam logic [31:0] WIN_FIRST = 32'h8000_1001;
  localparam logic [31:0] WIN_SPAN  = 32'h8000_8080 - 32'h8000_1001;

  localparam logic [31:0] A_LIR   = 32'h8000_1001;
  localparam logic [31:0] A_USR   = 32'h8000_2013;
  localparam logic [31:0] A_UCR   = 32'h8000_2017;
  localparam logic [31:0] A_UTHR  = 32'h8000_2019;
  localparam logic [31:0] A_URHR  = 32'h8000_201B;
  localparam logic [31:0] A_TSR   = 32'h8000_2020;
  localparam logic [31:0] A_TCR   = 32'h8000_2021;
  localparam logic [31:0] A_RRH   = 32'h8000_2022;
  localparam logic [31:0] A_RRL   = 32'h8000_2023;
  localparam logic [31:0] A_T0H   = 32'h8000_2024;
  localparam logic [31:0] A_T0L   = 32'h8000_2025;
  localparam logic [31:0] A_T1H   = 32'h8000_2026;
  localparam logic [31:0] A_T1L   = 32'h8000_2027;
  localparam logic [31:0] A_T2H   = 32'h8000_2028;
  localparam logic [31:0] A_T2L   = 32'h8000_2029;
  localparam logic [31:0] A_PICR1 = 32'h8000_2045;
  localparam logic [31:0] A_MSR   = 32'h8000_8000;

  // register selector codes
  localparam logic [4:0] SEL_NONE  = 5'd0;
  localparam logic [4:0] SEL_LIR   = 5'd1;
  localparam logic [4:0] SEL_USR   = 5'd2;
  localparam logic [4:0] SEL_UCR   = 5'd3;
  localparam logic [4:0] SEL_UTHR  = 5'd4;
  localparam logic [4:0] SEL_URHR  = 5'd5;
  localparam logic [4:0] SEL_TSR   = 5'd6;
  localparam logic [4:0] SEL_TCR   = 5'd7;
  localparam logic [4:0] SEL_RRH   = 5'd8;
  localparam logic [4:0] SEL_RRL   = 5'd9;
  localparam logic [4:0] SEL_T0H   = 5'd10;
  localparam logic [4:0] SEL_T0L   = 5'd11;
  localparam logic [4:0] SEL_T1H   = 5'd12;
  localparam logic [4:0] SEL_T1L   = 5'd13;
  localparam logic [4:0] SEL_T2H   = 5'd14;
  localparam logic [4:0] SEL_T2L   = 5'd15;
  localparam logic [4:0] SEL_PICR1 = 5'd16;
  localparam logic [4:0] SEL_MSR   = 5'd17;

  localparam logic [7:0] LIR_MASK   = 8'h77;
  localparam logic [7:0] UCR_CMD    = 8'h70;
  localparam logic [7:0] CMD_RXRST  = 8'h20;
  localparam logic [7:0] CMD_TXRST  = 8'h30;
  localparam logic [7:0] CMD_STCLR  = 8'h40;
  localparam logic [7:0] USR_RESET  = 8'h04;
  localparam logic [15:0] TMR_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [2:0]  access_bytes;
    logic [31:0] write_data;
    logic [15:0] elapsed_cycles;
  } req_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic [2:0]  irq_level;
    logic [6:0]  line_interrupt_value;
  } rsp_item_t;

  typedef struct packed {
    logic [7:0]  tsr;
    logic [7:0]  tcr;
    logic [15:0] rr;
    logic [15:0] t0;
    logic [15:0] t1;
    logic [15:0] t2;
  } tmr_t;

endpackage

@@ hdl/otu_timer_step.sv @@
`timescale 1ns / 1ps
// One prescaler tick applied to the timer registers.
// Depends on otu_pkg.
module otu_timer_step (
  input  otu_pkg::tmr_t cur,
  output otu_pkg::tmr_t nxt,
  output logic          raise
);
  import otu_pkg::*;

  // returns {raise, status, timer}
  function automatic logic [24:0] side(input logic [15:0] t, input logic [7:0] st,
                                       input logic [7:0] ctl, input logic [7:0] field,
                                       input logic [7:0] ovf, input logic [7:0] clr,
                                       input logic [7:0] match, input logic [15:0] t0n);
    logic [15:0] tn;
    logic [7:0]  s;
    logic        r;
    s = st;
    r = 1'b0;
    tn = t;
    if ((ctl & field) != 8'h00) begin
      if (t == TMR_MAX) begin
        s = s | ovf;
        r = 1'b1;
      end else if ((ctl & field) == field) begin
        s = s & ~clr;
      end
      tn = t + 16'd1;
      if (tn == t0n) s = s | match;
    end
    return {r, s, tn};
  endfunction

  logic [15:0] t0n;
  logic [7:0]  st0;
  logic        r0;
  logic [24:0] s1, s2;

  always_comb begin
    if (cur.t0 == TMR_MAX) begin
      t0n = cur.rr;
      st0 = cur.tsr | 8'h80;
      r0  = 1'b1;
    end else begin
      t0n = cur.t0 + 16'd1;
      st0 = cur.tsr;
      r0  = 1'b0;
    end
    s1 = side(cur.t1, st0, cur.tcr, 8'h30, 8'h10, 8'h11, 8'h40, t0n);
    s2 = side(cur.t2, s1[23:16], cur.tcr, 8'h03, 8'h02, 8'h03, 8'h08, t0n);
    nxt     = cur;
    nxt.t0  = t0n;
    nxt.t1  = s1[15:0];
    nxt.t2  = s2[15:0];
    nxt.tsr = s2[23:16];
    raise   = r0 | s1[24] | s2[24];
  end

endmodule

@@ hdl/onchip_timer_uart_register_block.sv @@
`timescale 1ns / 1ps
// Top level: sequencer, special registers and byte store.
// Depends on otu_pkg and otu_timer_step.
//
// After reset the block sweeps all STORE_BYTES bytes of its store to zero, one
// byte a cycle, before it takes its first item. A bus item handles one byte
// a cycle, but a byte read from plain storage also passes ST_RDATA
// (registered memory read). A time advance applies its prescaler ticks one a
// cycle: the single timer step unit applies one tick a cycle while the
// prescaler subtracts the divisor. The next item is taken while the result
// still waits in the output register.
module onchip_timer_uart_register_block #(
  parameter int STORE_BYTES      = 32768,
  parameter int PRESCALE_DIVISOR = 96
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  otu_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output otu_pkg::rsp_item_t rsp
);
  import otu_pkg::*;

  localparam int MW    = $clog2(STORE_BYTES);
  localparam int ACC_W = $clog2(65536 + PRESCALE_DIVISOR);
  localparam int RES_W = (PRESCALE_DIVISOR > 1) ? $clog2(PRESCALE_DIVISOR) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_BYTE  = 3'd2;
  localparam logic [2:0] ST_RDATA = 3'd3;
  localparam logic [2:0] ST_TICK  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state;
  logic [MW-1:0] clr_idx;

  // item held during processing
  logic [1:0]  act;
  logic [31:0] addr;
  logic [2:0]  nbytes;
  logic [31:0] wdata;
  logic [2:0]  idx;
  logic [31:0] rd;
  logic        irq_seen;
  logic [ACC_W-1:0] acc;
  logic [RES_W-1:0] residue;

  // special registers
  logic [7:0] lir, usr, ucr, uthr, urhr, picr;
  tmr_t       tmr;
  logic [7:0] lir_next, usr_next, ucr_next, uthr_next, urhr_next, picr_next;
  tmr_t       tmr_next, tick_nxt;
  logic       tick_raise;

  // byte store
  logic [7:0]    mem [STORE_BYTES];
  logic          mem_we;
  logic [MW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [MW-1:0] mem_raddr;
  logic [7:0]    mem_q;

  logic [31:0] a, off;
  logic        win, busy_byte, tick_go;
  logic [4:0]  sel;
  logic [1:0]  sh;
  logic [7:0]  wbyte, sbyte;
  logic [2:0]  n_sat;

  otu_timer_step u_step (.cur(tmr), .nxt(tick_nxt), .raise(tick_raise));

  assign n_sat     = (req.access_bytes > 3'd4) ? 3'd4 : req.access_bytes;
  assign a         = addr + {29'd0, idx};
  assign off       = a - WIN_FIRST;
  assign win       = (off <= WIN_SPAN) && (off < 32'(STORE_BYTES));
  assign busy_byte = (state == ST_BYTE) && (idx < nbytes) && win;
  assign sh        = 2'(nbytes - idx - 3'd1);
  assign wbyte     = wdata[{sh, 3'b000} +: 8];
  assign tick_go   = (state == ST_TICK) && (acc >= ACC_W'(PRESCALE_DIVISOR));
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    case (a)
      A_LIR:   sel = SEL_LIR;
      A_USR:   sel = SEL_USR;
      A_UCR:   sel = SEL_UCR;
      A_UTHR:  sel = SEL_UTHR;
      A_URHR:  sel = SEL_URHR;
      A_TSR:   sel = SEL_TSR;
      A_TCR:   sel = SEL_TCR;
      A_RRH:   sel = SEL_RRH;
      A_RRL:   sel = SEL_RRL;
      A_T0H:   sel = SEL_T0H;
      A_T0L:   sel = SEL_T0L;
      A_T1H:   sel = SEL_T1H;
      A_T1L:   sel = SEL_T1L;
      A_T2H:   sel = SEL_T2H;
      A_T2L:   sel = SEL_T2L;
      A_PICR1: sel = SEL_PICR1;
      A_MSR:   sel = SEL_MSR;
      default: sel = SEL_NONE;
    endcase
  end

  // read value of a special register (receive holding reads as cleared)
  always_comb begin
    case (sel)
      SEL_LIR:   sbyte = lir;
      SEL_USR:   sbyte = usr;
      SEL_UCR:   sbyte = ucr;
      SEL_UTHR:  sbyte = uthr;
      SEL_TSR:   sbyte = tmr.tsr;
      SEL_TCR:   sbyte = tmr.tcr;
      SEL_RRH:   sbyte = tmr.rr[15:8];
      SEL_RRL:   sbyte = tmr.rr[7:0];
      SEL_T0H:   sbyte = tmr.t0[15:8];
      SEL_T0L:   sbyte = tmr.t0[7:0];
      SEL_T1H:   sbyte = tmr.t1[15:8];
      SEL_T1L:   sbyte = tmr.t1[7:0];
      SEL_T2H:   sbyte = tmr.t2[15:8];
      SEL_T2L:   sbyte = tmr.t2[7:0];
      SEL_PICR1: sbyte = picr;
      default:   sbyte = 8'h00;
    endcase
  end

  always_comb begin
    lir_next  = lir;
    usr_next  = usr;
    ucr_next  = ucr;
    uthr_next = uthr;
    urhr_next = urhr;
    picr_next = picr;
    tmr_next  = tmr;
    if (busy_byte && act == ACT_READ && sel == SEL_URHR) begin
      urhr_next = 8'h00;
      usr_next  = usr & 8'hFE;
    end
    if (busy_byte && act == ACT_WRITE) begin
      case (sel)
        SEL_LIR:   lir_next = wbyte & LIR_MASK;
        SEL_USR:   usr_next = wbyte;
        SEL_UCR: begin
          case (wbyte & UCR_CMD)
            CMD_RXRST: begin
              urhr_next = 8'h00;
              usr_next  = usr & 8'hFE;
            end
            CMD_TXRST: begin
              uthr_next = 8'h00;
              usr_next  = usr | 8'h0C;
            end
            CMD_STCLR: usr_next = usr & 8'h0F;
            default: ;
          endcase
          ucr_next = wbyte;
        end
        SEL_UTHR: begin
          uthr_next = wbyte;
          usr_next  = usr | 8'h08;
        end
        SEL_URHR:  urhr_next = wbyte;
        SEL_TSR:   tmr_next.tsr = tmr.tsr & ~wbyte;
        SEL_TCR:   tmr_next.tcr = wbyte;
        SEL_RRH:   tmr_next.rr[15:8] = wbyte;
        SEL_RRL:   tmr_next.rr[7:0] = wbyte;
        SEL_T0H:   tmr_next.t0[15:8] = wbyte;
        SEL_T0L:   tmr_next.t0[7:0] = wbyte;
        SEL_T1H:   tmr_next.t1[15:8] = wbyte;
        SEL_T1L:   tmr_next.t1[7:0] = wbyte;
        SEL_T2H:   tmr_next.t2[15:8] = wbyte;
        SEL_T2L:   tmr_next.t2[7:0] = wbyte;
        SEL_PICR1: picr_next = wbyte;
        default: ;
      endcase
    end
    if (tick_go) tmr_next = tick_nxt;
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = 8'h00;
    end else begin
      mem_we    = busy_byte && act == ACT_WRITE && sel == SEL_NONE;
      mem_waddr = off[MW-1:0];
      mem_wdata = wbyte;
    end
    mem_raddr = off[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
      residue   <= '0;
      lir       <= 8'h00;
      usr       <= USR_RESET;
      ucr       <= 8'h00;
      uthr      <= 8'h00;
      urhr      <= 8'h00;
      picr      <= 8'h00;
      tmr       <= '0;
      irq_seen  <= 1'b0;
      idx       <= '0;
    end else begin
      lir  <= lir_next;
      usr  <= usr_next;
      ucr  <= ucr_next;
      uthr <= uthr_next;
      urhr <= urhr_next;
      picr <= picr_next;
      tmr  <= tmr_next;
      if (state == ST_DONE && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == MW'(STORE_BYTES - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_valid) begin
            act      <= req.action;
            addr     <= req.address;
            nbytes   <= n_sat;
            wdata    <= req.write_data;
            idx      <= '0;
            rd       <= '0;
            irq_seen <= 1'b0;
            acc      <= ACC_W'(residue) + ACC_W'(req.elapsed_cycles);
            if (req.action == ACT_READ || req.action == ACT_WRITE) state <= ST_BYTE;
            else if (req.action == ACT_ADVANCE) state <= ST_TICK;
            else state <= ST_DONE;
          end
        end
        ST_BYTE: begin
          if (idx >= nbytes) begin
            state <= ST_DONE;
          end else if (act == ACT_READ && win && sel == SEL_NONE) begin
            state <= ST_RDATA;
          end else begin
            if (act == ACT_READ) rd <= {rd[23:0], win ? sbyte : 8'h00};
            idx <= idx + 3'd1;
          end
        end
        ST_RDATA: begin
          rd    <= {rd[23:0], mem_q};
          idx   <= idx + 3'd1;
          state <= ST_BYTE;
        end
        ST_TICK: begin
          if (tick_go) begin
            acc <= acc - ACC_W'(PRESCALE_DIVISOR);
            if (tick_raise && picr[2:0] != 3'd0) irq_seen <= 1'b1;
          end else begin
            residue <= acc[RES_W-1:0];
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.read_data            <= (act == ACT_READ) ? rd : 32'h0;
            rsp.irq_request          <= irq_seen;
            rsp.irq_level            <= irq_seen ? picr[2:0] : 3'd0;
            rsp.line_interrupt_value <= lir[6:0];
            state                    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ready_drops: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item taken while busy");

  a_level_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.irq_request == (rsp.irq_level != 3'd0)))
    else $error("irq level disagrees with request");

  a_lir_mask: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !rsp.line_interrupt_value[3])
    else $error("line interrupt value not masked");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK || state == ST_CLEAR) |-> !req_ready)
    else $error("ready during tick or clear");

endmodule
